// ----- sv/llcbc_pkg.sv -----
// ----------------------------------------------------------------------------
// llcbc_pkg - shared types for the locked lru chunk buffer cache
// Slot count, field widths, state machine, status codes and the
// request/result structs.
// ----------------------------------------------------------------------------
package llcbc_pkg;

  // slot table geometry
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  // field widths
  localparam int CHUNK_W   = 24;
  localparam int PIN_W     = 8;
  localparam int STAMP_W   = 32;
  localparam int OUT_SLOT_W = 6;

  localparam logic [PIN_W-1:0]   PIN_MAX   = '1;
  localparam logic [STAMP_W-1:0] CLOCK_MAX = '1;

  // request operation
  typedef enum logic [0:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_ALLOC    = 3'd1,
    ST_NOFREE   = 3'd2,
    ST_RELEASED = 3'd3,
    ST_RELERR   = 3'd4,
    ST_PINFULL  = 3'd5
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    op_t                op;
    logic [CHUNK_W-1:0] chunk_index;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [PIN_W-1:0]      pin_count;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic scan_step;
    logic commit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/llcbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// llcbc_ctrl - request sequencer
// Takes one request, steps the datapath through the slot scan, then
// commits the update and result once the output register is free.
// ----------------------------------------------------------------------------
module llcbc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  llcbc_pkg::sts_t   sts,
  output llcbc_pkg::cmd_t   cmd
);

  llcbc_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= llcbc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    in_stall      = 1'b1;
    cmd.load_req  = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      llcbc_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = llcbc_pkg::S_SCAN;
        end
      end
      llcbc_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = llcbc_pkg::S_FINISH;
        end
      end
      llcbc_pkg::S_FINISH: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = llcbc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = llcbc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/llcbc_dp.sv -----
// ----------------------------------------------------------------------------
// llcbc_dp - slot table and scan datapath
// Holds the slot registers and access clock, walks one slot per cycle
// looking for a match and the oldest unpinned slot, then applies the
// update and loads the result register.
// ----------------------------------------------------------------------------
module llcbc_dp (
  input  logic              clk,
  input  logic              rst,
  input  llcbc_pkg::req_t   in_item,
  input  llcbc_pkg::cmd_t   cmd,
  output llcbc_pkg::sts_t   sts,
  output logic              out_valid,
  input  logic              out_stall,
  output llcbc_pkg::rsp_t   out_item
);

  // slot table
  logic                            slot_valid [llcbc_pkg::NUM_SLOTS];
  logic [llcbc_pkg::CHUNK_W-1:0]   slot_chunk [llcbc_pkg::NUM_SLOTS];
  logic [llcbc_pkg::PIN_W-1:0]     slot_pins  [llcbc_pkg::NUM_SLOTS];
  logic [llcbc_pkg::STAMP_W-1:0]   slot_stamp [llcbc_pkg::NUM_SLOTS];
  logic [llcbc_pkg::STAMP_W-1:0]   access_clock;

  // request and scan registers
  llcbc_pkg::req_t                 req;
  logic [llcbc_pkg::SLOT_W-1:0]    scan_idx;
  logic                            match_found;
  logic [llcbc_pkg::SLOT_W-1:0]    match_idx;
  logic [llcbc_pkg::PIN_W-1:0]     match_pins;
  logic                            best_found;
  logic [llcbc_pkg::SLOT_W-1:0]    best_idx;
  logic [llcbc_pkg::STAMP_W-1:0]   best_stamp;

  // scan compare on the current slot
  logic                            cur_match;
  logic                            cur_free;
  logic [llcbc_pkg::STAMP_W-1:0]   cur_stamp;

  assign cur_match = slot_valid[scan_idx] && (slot_chunk[scan_idx] == req.chunk_index);
  assign cur_free  = (slot_pins[scan_idx] == '0);
  assign cur_stamp = slot_valid[scan_idx] ? slot_stamp[scan_idx] : '0;

  assign sts.scan_last = (scan_idx == llcbc_pkg::SLOT_W'(llcbc_pkg::NUM_SLOTS - 1));
  assign sts.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req <= in_item;
    end
  end

  // scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx    <= '0;
      match_found <= 1'b0;
      best_found  <= 1'b0;
    end else if (cmd.load_req) begin
      scan_idx    <= '0;
      match_found <= 1'b0;
      best_found  <= 1'b0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + 1'b1;
      if (cur_match && !match_found) begin
        match_found <= 1'b1;
        match_idx   <= scan_idx;
        match_pins  <= slot_pins[scan_idx];
      end
      if (cur_free && (!best_found || (cur_stamp < best_stamp))) begin
        best_found <= 1'b1;
        best_idx   <= scan_idx;
        best_stamp <= cur_stamp;
      end
    end
  end

  // decision at commit
  llcbc_pkg::rsp_t               rsp;
  logic                          wr_en;
  logic                          wr_alloc;
  logic                          wr_touch;
  logic [llcbc_pkg::SLOT_W-1:0]  wr_idx;
  logic [llcbc_pkg::PIN_W-1:0]   wr_pins;

  always_comb begin
    rsp.status    = llcbc_pkg::ST_NOFREE;
    rsp.slot      = '0;
    rsp.pin_count = '0;
    wr_en    = 1'b0;
    wr_alloc = 1'b0;
    wr_touch = 1'b0;
    wr_idx   = match_idx;
    wr_pins  = match_pins;
    if (req.op == llcbc_pkg::OP_ACQUIRE) begin
      if (match_found) begin
        rsp.slot = llcbc_pkg::OUT_SLOT_W'(match_idx);
        if (match_pins == llcbc_pkg::PIN_MAX) begin
          rsp.status    = llcbc_pkg::ST_PINFULL;
          rsp.pin_count = llcbc_pkg::PIN_MAX;
        end else begin
          wr_en         = 1'b1;
          wr_touch      = 1'b1;
          wr_pins       = match_pins + 1'b1;
          rsp.status    = llcbc_pkg::ST_HIT;
          rsp.pin_count = wr_pins;
        end
      end else if (best_found) begin
        wr_en         = 1'b1;
        wr_alloc      = 1'b1;
        wr_touch      = 1'b1;
        wr_idx        = best_idx;
        wr_pins       = llcbc_pkg::PIN_W'(1);
        rsp.status    = llcbc_pkg::ST_ALLOC;
        rsp.slot      = llcbc_pkg::OUT_SLOT_W'(best_idx);
        rsp.pin_count = wr_pins;
      end
    end else begin
      if (!match_found) begin
        rsp.status = llcbc_pkg::ST_RELERR;
      end else if (match_pins == '0) begin
        rsp.status = llcbc_pkg::ST_RELERR;
        rsp.slot   = llcbc_pkg::OUT_SLOT_W'(match_idx);
      end else begin
        wr_en         = 1'b1;
        wr_pins       = match_pins - 1'b1;
        rsp.status    = llcbc_pkg::ST_RELEASED;
        rsp.slot      = llcbc_pkg::OUT_SLOT_W'(match_idx);
        rsp.pin_count = wr_pins;
      end
    end
  end

  // slot table update, control part
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < llcbc_pkg::NUM_SLOTS; i++) begin
        slot_valid[i] <= 1'b0;
        slot_pins[i]  <= '0;
      end
      access_clock <= llcbc_pkg::STAMP_W'(1);
    end else if (cmd.commit && wr_en) begin
      slot_pins[wr_idx] <= wr_pins;
      if (wr_alloc) begin
        slot_valid[wr_idx] <= 1'b1;
      end
      if (wr_touch && (access_clock != llcbc_pkg::CLOCK_MAX)) begin
        access_clock <= access_clock + 1'b1;
      end
    end
  end

  // slot table update, payload part
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      if (wr_alloc) begin
        slot_chunk[wr_idx] <= req.chunk_index;
      end
      if (wr_touch) begin
        slot_stamp[wr_idx] <= access_clock;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item <= rsp;
    end
  end

endmodule

// ----- sv/locked_lru_chunk_buffer_cache_core.sv -----
// ----------------------------------------------------------------------------
// locked_lru_chunk_buffer_cache_core - pinned lru chunk buffer cache
// Acquire and release of chunk buffer slots with pin counts and
// lru replacement over unpinned slots.
// ----------------------------------------------------------------------------
//
//   channel   handshake            payload
//   -------   ------------------   ------------------------------------
//   request   in_valid / in_stall  in_item  (op, chunk_index)
//   result    out_valid/ out_stall out_item (status, slot, pin_count)
//
// each request is latched, then the slot table is scanned slot by slot for the
// match / oldest-unpinned slot, then the update and result are committed.
// one result per request; a finished result waits in the output register
// while the next request is taken, and the commit waits if it is still held.
// reset (synchronous, active high) clears all slots and sets the clock to 1.
module locked_lru_chunk_buffer_cache_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  llcbc_pkg::req_t   in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output llcbc_pkg::rsp_t   out_item
);

  llcbc_pkg::cmd_t cmd;
  llcbc_pkg::sts_t sts;

  // sequencer
  llcbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot table and scan
  llcbc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a taken request blocks the port until its result is committed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request port open right after a request was taken");

  // a no free slot result reports slot and pins as zero
  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.status == llcbc_pkg::ST_NOFREE)) |->
      ((out_item.slot == '0) && (out_item.pin_count == '0)))
    else $error("no free slot result carries a slot or pin count");

  // allocation always leaves exactly one pin
  a_alloc_one_pin: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.status == llcbc_pkg::ST_ALLOC)) |->
      (out_item.pin_count == llcbc_pkg::PIN_W'(1)))
    else $error("allocated slot does not report one pin");

  // a hit leaves the slot pinned
  a_hit_pinned: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.status == llcbc_pkg::ST_HIT)) |->
      (out_item.pin_count != '0))
    else $error("hit reports zero pins");

endmodule

// ----- test/slot_table_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_table_check - result checker for the locked lru chunk buffer cache
// Watches both channels, keeps its own copy of the slot table and access
// clock, works out the result of every accepted request and compares each
// accepted result, field by field, with the oldest outstanding one.
// ----------------------------------------------------------------------------
module slot_table_check (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_stall,
  input  llcbc_pkg::req_t in_item,
  input  logic            out_valid,
  input  logic            out_stall,
  input  llcbc_pkg::rsp_t out_item,
  output int              errors,
  output int              pending
);

  localparam int PRINT_CAP = 50;

  // shadow slot table
  logic                          held    [llcbc_pkg::NUM_SLOTS];
  logic [llcbc_pkg::CHUNK_W-1:0] owner   [llcbc_pkg::NUM_SLOTS];
  logic [llcbc_pkg::PIN_W-1:0]   pins    [llcbc_pkg::NUM_SLOTS];
  logic [llcbc_pkg::STAMP_W-1:0] stamp   [llcbc_pkg::NUM_SLOTS];
  logic [llcbc_pkg::STAMP_W-1:0] access_clock;

  llcbc_pkg::rsp_t outstanding_results [$];
  llcbc_pkg::rsp_t want;

  initial errors = 0;

  task automatic report_mismatch(input string msg);
    if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input int got, input int exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s got %0d, want %0d", name, got, exp_val));
  endtask

  // stamp a slot with the clock, clock sticks at its top value
  function automatic void touch_slot(input int s);
    stamp[s] = access_clock;
    if (access_clock != llcbc_pkg::CLOCK_MAX) access_clock++;
  endfunction

  // apply one request to the shadow table and return its result
  function automatic llcbc_pkg::rsp_t resolve_request(input llcbc_pkg::req_t r);
    int                            hit;
    int                            victim;
    logic [llcbc_pkg::STAMP_W-1:0] age;
    logic [llcbc_pkg::STAMP_W-1:0] victim_age;
    llcbc_pkg::rsp_t               res;
    hit        = -1;
    victim     = -1;
    victim_age = '0;
    res.status    = llcbc_pkg::ST_NOFREE;
    res.slot      = '0;
    res.pin_count = '0;
    // lowest valid slot holding the chunk
    for (int s = 0; s < llcbc_pkg::NUM_SLOTS; s++)
      if (hit < 0 && held[s] && owner[s] == r.chunk_index) hit = s;

    if (r.op == llcbc_pkg::OP_ACQUIRE) begin
      if (hit >= 0) begin
        if (pins[hit] == llcbc_pkg::PIN_MAX) begin
          res.status    = llcbc_pkg::ST_PINFULL;
          res.slot      = llcbc_pkg::OUT_SLOT_W'(hit);
          res.pin_count = llcbc_pkg::PIN_MAX;
        end else begin
          pins[hit]++;
          touch_slot(hit);
          res.status    = llcbc_pkg::ST_HIT;
          res.slot      = llcbc_pkg::OUT_SLOT_W'(hit);
          res.pin_count = pins[hit];
        end
      end else begin
        // oldest unpinned slot, invalid ones count as age zero, first wins ties
        for (int s = 0; s < llcbc_pkg::NUM_SLOTS; s++) begin
          if (pins[s] == '0) begin
            age = held[s] ? stamp[s] : '0;
            if (victim < 0 || age < victim_age) begin
              victim     = s;
              victim_age = age;
            end
          end
        end
        if (victim >= 0) begin
          held[victim]  = 1'b1;
          owner[victim] = r.chunk_index;
          pins[victim]  = llcbc_pkg::PIN_W'(1);
          touch_slot(victim);
          res.status    = llcbc_pkg::ST_ALLOC;
          res.slot      = llcbc_pkg::OUT_SLOT_W'(victim);
          res.pin_count = llcbc_pkg::PIN_W'(1);
        end
      end
    end else begin
      if (hit < 0) begin
        res.status = llcbc_pkg::ST_RELERR;
      end else if (pins[hit] == '0) begin
        res.status = llcbc_pkg::ST_RELERR;
        res.slot   = llcbc_pkg::OUT_SLOT_W'(hit);
      end else begin
        pins[hit]--;
        res.status    = llcbc_pkg::ST_RELEASED;
        res.slot      = llcbc_pkg::OUT_SLOT_W'(hit);
        res.pin_count = pins[hit];
      end
    end
    return res;
  endfunction

  // channel monitor
  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < llcbc_pkg::NUM_SLOTS; s++) begin
        held[s]  = 1'b0;
        owner[s] = '0;
        pins[s]  = '0;
        stamp[s] = '0;
      end
      access_clock = llcbc_pkg::STAMP_W'(1);
      outstanding_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (outstanding_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d slot %0d pins %0d",
                                    out_item.status, out_item.slot, out_item.pin_count));
        end else begin
          want = outstanding_results.pop_front();
          compare_field("status", int'(out_item.status), int'(want.status));
          compare_field("slot", int'(out_item.slot), int'(want.slot));
          compare_field("pin_count", int'(out_item.pin_count), int'(want.pin_count));
        end
      end
      if (in_valid && !in_stall)
        outstanding_results.push_back(resolve_request(in_item));
    end
    pending <= outstanding_results.size();
  end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for the locked lru chunk buffer cache
// Directed acquire/release sequences for hits, allocation order, full table,
// unmatched and zero-pin releases and pin saturation, then a random mix of
// pin runs, table fills and noise under random idle bursts on both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int ITEMS        = 1850;
  localparam int CALM_TAIL    = 150;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4 * (llcbc_pkg::NUM_SLOTS + 2);
  localparam int POOL_SIZE    = 12;
  localparam int FILL_COUNT   = 8;
  localparam logic [FILL_COUNT*llcbc_pkg::CHUNK_W-1:0] FILL_CHUNKS = {
    24'h555555, 24'hAAAAAA, 24'h000001, 24'h800000,
    24'h7FFFFF, 24'hFFFFFE, 24'h0F0F0F, 24'hF0F0F0
  };

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  llcbc_pkg::req_t in_item   = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  llcbc_pkg::rsp_t out_item;

  int   errors;
  int   pending;
  int   sent         = 0;
  int   quiet_cycles = 0;
  logic bursts_on    = 1'b1;
  logic [llcbc_pkg::CHUNK_W-1:0] pool [POOL_SIZE];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  locked_lru_chunk_buffer_cache_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  slot_table_check check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .errors    (errors),
    .pending   (pending)
  );

  // one request, with an occasional idle burst ahead of it
  task automatic send_request(input llcbc_pkg::op_t op,
                              input logic [llcbc_pkg::CHUNK_W-1:0] chunk);
    llcbc_pkg::req_t r;
    r.op          = op;
    r.chunk_index = chunk;
    bursts_on = (sent < ITEMS - CALM_TAIL);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // result-side stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (bursts_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int                            k;
    int                            n;
    int                            base;
    logic [llcbc_pkg::CHUNK_W-1:0] hammer_chunk;
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = llcbc_pkg::CHUNK_W'($urandom());
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // release before anything is held: invalid slots never match
    send_request(llcbc_pkg::OP_RELEASE, 24'h000000);
    // allocate both extremes, hit, then release down past zero
    send_request(llcbc_pkg::OP_ACQUIRE, 24'h000000);
    send_request(llcbc_pkg::OP_ACQUIRE, 24'hFFFFFF);
    send_request(llcbc_pkg::OP_ACQUIRE, 24'h000000);
    send_request(llcbc_pkg::OP_RELEASE, 24'h000000);
    send_request(llcbc_pkg::OP_RELEASE, 24'h000000);
    send_request(llcbc_pkg::OP_RELEASE, 24'h000000);
    send_request(llcbc_pkg::OP_RELEASE, 24'hFFFFFF);
    // fill: invalid slots first, then the older of the two released ones, then the other
    for (int i = 0; i < FILL_COUNT; i++)
      send_request(llcbc_pkg::OP_ACQUIRE,
                   FILL_CHUNKS[i*llcbc_pkg::CHUNK_W +: llcbc_pkg::CHUNK_W]);
    // every slot pinned
    send_request(llcbc_pkg::OP_ACQUIRE, 24'h123456);
    // evicted chunk no longer matches
    send_request(llcbc_pkg::OP_RELEASE, 24'hFFFFFF);
    for (int i = 0; i < FILL_COUNT; i++)
      send_request(llcbc_pkg::OP_RELEASE,
                   FILL_CHUNKS[i*llcbc_pkg::CHUNK_W +: llcbc_pkg::CHUNK_W]);

    // pin one chunk up to saturation and past it, then unpin past zero
    hammer_chunk = llcbc_pkg::CHUNK_W'($urandom());
    repeat (int'(llcbc_pkg::PIN_MAX) + 2) send_request(llcbc_pkg::OP_ACQUIRE, hammer_chunk);
    repeat (int'(llcbc_pkg::PIN_MAX) + 1) send_request(llcbc_pkg::OP_RELEASE, hammer_chunk);

    // random mix
    while (sent < ITEMS) begin
      k = $urandom_range(0, 99);
      if (k < 40) begin
        // single op on a pooled chunk, leaning to release so pins drain
        send_request(($urandom_range(0, 9) < 6) ? llcbc_pkg::OP_RELEASE
                                                : llcbc_pkg::OP_ACQUIRE,
                     pool[$urandom_range(0, POOL_SIZE - 1)]);
      end else if (k < 65) begin
        // pin run on one chunk
        base = $urandom_range(0, POOL_SIZE - 1);
        n    = $urandom_range(1, 6);
        repeat (n) send_request(llcbc_pkg::OP_ACQUIRE, pool[base]);
        repeat (n + $urandom_range(0, 1)) send_request(llcbc_pkg::OP_RELEASE, pool[base]);
      end else if (k < 80) begin
        // more chunks than slots, then release them all
        base = $urandom_range(0, POOL_SIZE - 1);
        for (int i = 0; i < llcbc_pkg::NUM_SLOTS + 1; i++)
          send_request(llcbc_pkg::OP_ACQUIRE, pool[(base + i) % POOL_SIZE]);
        for (int i = 0; i < llcbc_pkg::NUM_SLOTS + 1; i++)
          send_request(llcbc_pkg::OP_RELEASE, pool[(base + i) % POOL_SIZE]);
      end else begin
        // noise over the whole chunk range
        send_request($urandom_range(0, 1) ? llcbc_pkg::OP_RELEASE : llcbc_pkg::OP_ACQUIRE,
                     llcbc_pkg::CHUNK_W'($urandom()));
      end
    end
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
